// ----- hdl/bdpc_pkg.sv -----
package bdpc_pkg;

  localparam int unsigned CHOICE_W = 3;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned ADDR_W   = 3;

  // Register index, taken from paddr bit 2 (registers sit at byte 0 and 4).
  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_idx_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic                update_pulse;
    logic                select_pulse;
    logic [CHOICE_W-1:0] selected_choice;
    logic [CHOICE_W-1:0] active_choice;
  } res_t;

endpackage

// ----- hdl/bdpc_cfg.sv -----
module bdpc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bdpc_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready,
  output bdpc_pkg::cfg_t                  cfg
);

  logic [bdpc_pkg::CFG_W-1:0] debounce_r;
  logic [bdpc_pkg::CFG_W-1:0] long_press_r;
  logic                       wr_en;
  bdpc_pkg::reg_idx_t         idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = bdpc_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= bdpc_pkg::DEBOUNCE_RST;
      long_press_r <= bdpc_pkg::LONG_PRESS_RST;
    end else if (wr_en) begin
      unique case (idx)
        bdpc_pkg::REG_DEBOUNCE:   debounce_r   <= cfg_pwdata[bdpc_pkg::CFG_W-1:0];
        bdpc_pkg::REG_LONG_PRESS: long_press_r <= cfg_pwdata[bdpc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bdpc_pkg::REG_DEBOUNCE:   cfg_prdata = {16'd0, debounce_r};
      bdpc_pkg::REG_LONG_PRESS: cfg_prdata = {16'd0, long_press_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.debounce_ms   = debounce_r;
  assign cfg.long_press_ms = long_press_r;

endmodule

// ----- hdl/bdpc_core.sv -----
module bdpc_core #(
  parameter int unsigned NUM_CHOICES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic           level,
  input  bdpc_pkg::cfg_t cfg,
  output bdpc_pkg::res_t res
);

  localparam int unsigned MW = bdpc_pkg::MS_W;
  localparam int unsigned CW = bdpc_pkg::CHOICE_W;

  logic [MW-1:0] ms_r, ms_nxt;
  logic [MW-1:0] lock_end_r, lock_end_nxt;
  logic [MW-1:0] press_r, press_nxt;
  logic          lock_on_r, lock_on_nxt;
  logic          armed_r, armed_nxt;
  logic          exp_fall_r, exp_fall_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] active_r, active_nxt;
  logic [CW-1:0] selected_r, selected_nxt;

  logic          fell, rose, take, long_hit, expire;
  logic          sel_p, upd_p;
  logic [MW:0]   end_sum;
  logic [MW-1:0] ms_inc, dur;

  always_comb begin
    ms_inc  = ms_r + 1'b1;
    fell    = last_r & ~level;
    rose    = ~last_r & level;
    take    = armed_r & (exp_fall_r ? fell : rose);
    end_sum = {1'b0, ms_inc} + {{(MW + 1 - bdpc_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
    dur     = ms_inc - press_r;
    long_hit = dur > {{(MW - bdpc_pkg::CFG_W){1'b0}}, cfg.long_press_ms};
    // A lockout set on this tick expires at once only if its end wrapped past zero.
    expire  = take ? end_sum[MW] : (lock_on_r & (ms_inc > lock_end_r));

    ms_nxt       = ms_r;
    lock_end_nxt = lock_end_r;
    press_nxt    = press_r;
    lock_on_nxt  = lock_on_r;
    armed_nxt    = armed_r;
    exp_fall_nxt = exp_fall_r;
    last_nxt     = last_r;
    active_nxt   = active_r;
    selected_nxt = selected_r;
    sel_p        = 1'b0;
    upd_p        = 1'b0;

    if (fire) begin
      ms_nxt   = ms_inc;
      last_nxt = level;
      if (take) begin
        armed_nxt    = 1'b0;
        lock_on_nxt  = 1'b1;
        lock_end_nxt = end_sum[MW-1:0];
        if (exp_fall_r) begin
          press_nxt = ms_inc;
        end else if (long_hit) begin
          selected_nxt = active_r;
          sel_p        = 1'b1;
        end else begin
          if (active_r >= CW'(NUM_CHOICES)) begin
            active_nxt = CW'(1);
          end else begin
            active_nxt = active_r + 1'b1;
          end
          upd_p = 1'b1;
        end
      end
      if (expire) begin
        lock_on_nxt  = 1'b0;
        armed_nxt    = 1'b1;
        exp_fall_nxt = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r       <= '0;
      lock_end_r <= '0;
      press_r    <= '0;
      lock_on_r  <= 1'b0;
      armed_r    <= 1'b1;
      exp_fall_r <= 1'b1;
      last_r     <= 1'b1;
      active_r   <= CW'(1);
      selected_r <= '0;
    end else begin
      ms_r       <= ms_nxt;
      lock_end_r <= lock_end_nxt;
      press_r    <= press_nxt;
      lock_on_r  <= lock_on_nxt;
      armed_r    <= armed_nxt;
      exp_fall_r <= exp_fall_nxt;
      last_r     <= last_nxt;
      active_r   <= active_nxt;
      selected_r <= selected_nxt;
    end
  end

  assign res.active_choice   = active_nxt;
  assign res.selected_choice = selected_nxt;
  assign res.select_pulse    = sel_p;
  assign res.update_pulse    = upd_p;

  a_arm_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(armed_r && lock_on_r))
    else $error("armed and lockout both set");

  a_sel_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && sel_p) |=> (selected_r == $past(active_r)))
    else $error("long press did not copy the active choice");

  a_active_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r >= CW'(1)) && (active_r <= CW'(NUM_CHOICES)))
    else $error("active choice out of range");

  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    !(sel_p && upd_p))
    else $error("select and update pulse together");

endmodule

// ----- hdl/button_debounce_press_classifier.sv -----
// A word accepted on in_ is held in the input register, then moves into the result
// register, from which it is shown on out_.
// Throughput: one word per cycle; the 32-bit tick counter's compares are combinational, and
// a stalled result lets the input register take one more word.
// Reset (rst_n low at a clock edge) empties both stages, returns both registers to their
// reset values, and returns the classifier to armed, released, first choice, none selected.
module button_debounce_press_classifier #(
  parameter int unsigned NUM_CHOICES = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [0] pin_level, [7:1] zero
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [2:0] active_choice,
                                                  // [5:3] selected_choice,
                                                  // [6] select_pulse, [7] update_pulse
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bdpc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  bdpc_pkg::cfg_t cfg;
  bdpc_pkg::res_t res;

  logic       s1_valid_r;
  logic       s1_level_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       fire;

  assign fire      = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | fire;

  bdpc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bdpc_core #(
    .NUM_CHOICES (NUM_CHOICES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .level (s1_level_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[0];
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !fire)
    else $error("result register overwritten while stalled");

  a_sel_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[5:3] <= 3'(NUM_CHOICES)))
    else $error("selected choice out of range");

  a_fire_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word lost");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NUM_CHOICES = 4;

  // Predicts the classifier tick by tick and holds the results still owed by the block.
  class press_scoreboard;
    bit [bdpc_pkg::CFG_W-1:0]    debounce_ms   = bdpc_pkg::DEBOUNCE_RST;
    bit [bdpc_pkg::CFG_W-1:0]    long_press_ms = bdpc_pkg::LONG_PRESS_RST;
    bit [bdpc_pkg::MS_W-1:0]     ms_count      = '0;
    bit [bdpc_pkg::MS_W-1:0]     lockout_end   = '0;
    bit [bdpc_pkg::MS_W-1:0]     press_start   = '0;
    bit                          lockout_on    = 1'b0;
    bit                          armed         = 1'b1;
    bit                          expect_falling = 1'b1;
    bit                          last_level    = 1'b1;
    bit [bdpc_pkg::CHOICE_W-1:0] active_reg    = 3'd1;
    bit [bdpc_pkg::CHOICE_W-1:0] selected_reg  = 3'd0;
    bdpc_pkg::res_t              expected_q[$];
    int                          mismatches    = 0;
    int                          long_presses  = 0;
    int                          short_presses = 0;

    function void write_register(bdpc_pkg::reg_idx_t idx, bit [bdpc_pkg::CFG_W-1:0] value);
      if (idx == bdpc_pkg::REG_DEBOUNCE) begin
        debounce_ms = value;
      end else begin
        long_press_ms = value;
      end
    endfunction

    function void note_tick(bit level);
      bdpc_pkg::res_t          r;
      bit                      fell;
      bit                      rose;
      bit [bdpc_pkg::MS_W-1:0] duration;
      fell = last_level && !level;
      rose = !last_level && level;
      r = '0;
      ms_count = ms_count + 1;
      if (armed && ((expect_falling && fell) || (!expect_falling && rose))) begin
        armed = 1'b0;
        lockout_on = 1'b1;
        lockout_end = ms_count + bdpc_pkg::MS_W'(debounce_ms);
        duration = ms_count - press_start;
        if (expect_falling) begin
          press_start = ms_count;
        end else if (duration > bdpc_pkg::MS_W'(long_press_ms)) begin
          selected_reg = active_reg;
          r.select_pulse = 1'b1;
          long_presses++;
        end else begin
          active_reg = (active_reg >= NUM_CHOICES) ? 3'd1 : active_reg + 3'd1;
          r.update_pulse = 1'b1;
          short_presses++;
        end
      end
      // The lockout compare is a plain unsigned one, so a wrapped end expires at once.
      if (lockout_on && ms_count > lockout_end) begin
        lockout_on = 1'b0;
        armed = 1'b1;
        expect_falling = level;
      end
      last_level = level;
      r.active_choice = active_reg;
      r.selected_choice = selected_reg;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] word);
      bdpc_pkg::res_t got;
      bdpc_pkg::res_t want;
      got = bdpc_pkg::res_t'(word);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result word %h arrived with nothing expected", $realtime, word);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.active_choice !== want.active_choice ||
          got.selected_choice !== want.selected_choice ||
          got.select_pulse !== want.select_pulse ||
          got.update_pulse !== want.update_pulse) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch active %0d/%0d selected %0d/%0d select %0d/%0d update %0d/%0d",
                   $realtime, want.active_choice, got.active_choice, want.selected_choice,
                   got.selected_choice, want.select_pulse, got.select_pulse,
                   want.update_pulse, got.update_pulse);
          $display("  (expected/actual)");
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata = '0;     // [0] pin_level, [7:1] zero
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;         // [2:0] active_choice,
                                                    // [5:3] selected_choice,
                                                    // [6] select_pulse, [7] update_pulse
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [bdpc_pkg::ADDR_W-1:0]   cfg_paddr = '0;
  logic [31:0]                   cfg_pwdata = '0;
  logic [31:0]                   cfg_prdata;
  logic                          cfg_pready;

  press_scoreboard sb;
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int ticks_sent = 0;
  int phase_ticks = 0;
  int settings_used = 0;
  bit failed;

  button_debounce_press_classifier #(.NUM_CHOICES(NUM_CHOICES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Result side: random stalls, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  function automatic int cap(int value, int limit);
    return (value > limit) ? limit : value;
  endfunction

  task automatic send_level(input bit level);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick(level);
    ticks_sent++;
    phase_ticks++;
  endtask

  task automatic write_reg(input bdpc_pkg::reg_idx_t idx,
                           input bit [bdpc_pkg::CFG_W-1:0] value);
    bit [15:0] junk;
    junk = 16'($urandom);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    // Upper bits carry junk; only the low 16 bits may land in the register.
    cfg_pwdata <= {junk, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_register(idx, value);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic hold_and_release(input int hold, input int rest);
    repeat (hold) send_level(1'b0);
    repeat (rest) send_level(1'b1);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // One button press with optional contact bounce at either edge.
  task automatic random_press(input int deb, input int lp);
    int hold;
    int rest;
    case ($urandom_range(3))
      0: hold = $urandom_range(1, 4);
      1: hold = $urandom_range(1, cap(lp, 40) + 1);
      2: hold = cap(lp, 40) + $urandom_range(0, 3);
      default: hold = $urandom_range(1, 45);
    endcase
    if (hold < 1) hold = 1;
    rest = $urandom_range(1, cap(deb, 30) + 4);
    if ($urandom_range(1)) begin
      repeat ($urandom_range(1, 3)) begin
        send_level(1'b0);
        send_level(1'b1);
      end
    end
    repeat (hold) send_level(1'b0);
    if ($urandom_range(1)) begin
      repeat ($urandom_range(1, 3)) begin
        send_level(1'b1);
        send_level(1'b0);
      end
    end
    repeat (rest) send_level(1'b1);
  endtask

  task automatic run_phase(input int src_pct, input int rx_pct, input int deb, input int lp,
                           input int budget, input bit pressure);
    bit held;
    held = 1'b0;
    drain_results();
    write_reg(bdpc_pkg::REG_DEBOUNCE, bdpc_pkg::CFG_W'(deb));
    write_reg(bdpc_pkg::REG_LONG_PRESS, bdpc_pkg::CFG_W'(lp));
    settings_used++;
    src_idle_pct = src_pct;
    rx_stall_pct = rx_pct;
    phase_ticks = 0;
    while (phase_ticks < budget) begin
      if (pressure && !held && phase_ticks > 40) begin
        hold_left = 150;
        held = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6)) send_level(1'($urandom_range(1)));
      end else begin
        random_press(deb, lp);
      end
    end
  endtask

  initial begin
    #400000;
    $display("button_debounce_press_classifier verification failed");
    $finish;
  end

  initial begin
    sb = new;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a press released inside the lockout, a short press, a long press,
    // then contact bounce around both edges.
    write_reg(bdpc_pkg::REG_DEBOUNCE, 16'd2);
    write_reg(bdpc_pkg::REG_LONG_PRESS, 16'd5);
    settings_used++;
    hold_and_release(2, 3);
    hold_and_release(4, 3);
    hold_and_release(6, 3);
    send_level(1'b0);
    send_level(1'b1);
    hold_and_release(3, 1);
    send_level(1'b0);
    hold_and_release(0, 3);

    run_phase(0, 0, 3, 12, 260, 1'b1);
    run_phase(80, 0, 0, 0, 260, 1'b0);
    run_phase(0, 80, 1, 65535, 260, 1'b0);
    run_phase(38, 38, 5, 20, 240, 1'b0);
    // A full-length lockout never expires within the run, so it comes last.
    run_phase(38, 38, 65535, 8, 40, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d button ticks under %0d register settings with idling on both sides.",
             ticks_sent, settings_used);
    $display("Predicted %0d long presses and %0d short presses; %0d words mismatched.",
             sb.long_presses, sb.short_presses, sb.mismatches);
    failed = (sb.mismatches != 0) || (sb.pending() != 0);
    if (!failed) begin
      $display("button_debounce_press_classifier verification clean");
    end else begin
      $display("button_debounce_press_classifier verification failed");
    end
    $finish;
  end

endmodule
